[sv/mkm_pkg.sv]
// Shared types and constants of the MurmurHash3 k-mer minimizer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mkm_pkg;

  localparam int KMER_LEN_W  = 6;
  localparam int SEED_W      = 64;
  localparam int WORD_W      = 64;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [KMER_LEN_W-1:0] KMER_LEN_RESET = 6'd15;
  localparam logic [KMER_LEN_W-1:0] KMER_LEN_MAX   = 6'd32;

  localparam logic [CFG_INDEX_W-1:0] CFG_KMER_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HASH_SEED   = 1'b1;

  localparam logic [WORD_W-1:0] MURMUR_C1 = 64'h87c3_7b91_1142_53d5;
  localparam logic [WORD_W-1:0] MURMUR_C2 = 64'h4cf5_ad43_2745_937f;
  localparam logic [WORD_W-1:0] FMIX_M1   = 64'hff51_afd7_ed55_8ccd;
  localparam logic [WORD_W-1:0] FMIX_M2   = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [WORD_W-1:0] START_MIN = 64'h7fff_ffff_ffff_ffff;
  localparam logic [WORD_W-1:0] BLOCK_LEN = 64'd8;

  typedef struct packed {
    logic [1:0] base_code;
    logic       last_base;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] minimizer_kmer;
    logic              found;
  } out_item_t;

  // One entry of the queue between front and back
  typedef struct packed {
    logic [WORD_W-1:0] kmer;
    logic              has_kmer;
    logic              last;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KM1,
    ST_KM2,
    ST_LANE1,
    ST_LANE2,
    ST_F1A,
    ST_F1B,
    ST_FIN1,
    ST_F2A,
    ST_F2B,
    ST_FIN2,
    ST_SUM,
    ST_EMIT
  } back_state_t;

  function automatic logic [WORD_W-1:0] xorshift33(input logic [WORD_W-1:0] x);
    xorshift33 = x ^ {33'd0, x[WORD_W-1:33]};
  endfunction

endpackage

`default_nettype wire

[sv/mkm_front.sv]
// Front part: takes bases, keeps the rolling window and posts jobs.
// Depends on mkm_pkg.
`default_nettype none

module mkm_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [mkm_pkg::KMER_LEN_W-1:0] kmer_length,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire mkm_pkg::in_item_t              in_data,
  output logic                                job_valid,
  input  wire logic                           job_ready,
  output mkm_pkg::job_t                       job_data
);

  logic [mkm_pkg::WORD_W-1:0]     window_r, window_nxt, win_shift, mask;
  logic [mkm_pkg::KMER_LEN_W-1:0] seen_r, seen_nxt, seen_inc, eff_k;
  logic [mkm_pkg::KMER_LEN_W:0]   shamt;
  logic                           accept, full;

  always_comb begin
    if (kmer_length == '0) begin
      eff_k = mkm_pkg::KMER_LEN_W'(1);
    end else if (kmer_length > mkm_pkg::KMER_LEN_MAX) begin
      eff_k = mkm_pkg::KMER_LEN_MAX;
    end else begin
      eff_k = kmer_length;
    end
  end

  // A shift of 64 leaves zero, so a 32-base window keeps every bit
  assign shamt     = {eff_k, 1'b0};
  assign mask      = ~({mkm_pkg::WORD_W{1'b1}} << shamt);
  assign win_shift = {window_r[mkm_pkg::WORD_W-3:0], in_data.base_code} & mask;
  assign seen_inc  = (seen_r < eff_k) ? seen_r + 1'b1 : eff_k;
  assign full      = (seen_inc == eff_k);

  assign in_ready  = job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = in_valid && (full || in_data.last_base);

  assign job_data.kmer     = win_shift;
  assign job_data.has_kmer = full;
  assign job_data.last     = in_data.last_base;

  always_comb begin
    window_nxt = window_r;
    seen_nxt   = seen_r;
    if (accept) begin
      // drop the sequence state after its last base
      if (in_data.last_base) begin
        window_nxt = '0;
        seen_nxt   = '0;
      end else begin
        window_nxt = win_shift;
        seen_nxt   = seen_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      seen_r   <= '0;
    end else begin
      window_r <= window_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/mkm_queue.sv]
// Short register queue of jobs between the front and the hash back end.
// Depends on mkm_pkg.
`default_nettype none

module mkm_queue #(
  parameter int DEPTH = mkm_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire mkm_pkg::job_t wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output mkm_pkg::job_t      rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mkm_pkg::job_t     entries_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = entries_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[sv/mkm_hash_back.sv]
// Back end: hashes each k-mer with a shared 32x32 multiplier, keeps the
// running minimum and holds the result register. Depends on mkm_pkg.
`default_nettype none

module mkm_hash_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [mkm_pkg::SEED_W-1:0] hash_seed,
  input  wire logic                       job_valid,
  output logic                            job_ready,
  input  wire mkm_pkg::job_t              job_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output mkm_pkg::out_item_t              out_data
);

  localparam int W = mkm_pkg::WORD_W;
  localparam int H = mkm_pkg::WORD_W / 2;

  mkm_pkg::back_state_t state_r, state_nxt;
  mkm_pkg::job_t        job_r, job_nxt;
  mkm_pkg::out_item_t   out_data_r, out_data_nxt;

  logic [1:0]   sub_r, sub_nxt;
  logic [W-1:0] acc_r, acc_nxt, opnd_r, opnd_nxt, l1_r, l1_nxt, l2_r, l2_nxt;
  logic [W-1:0] best_hash_r, best_hash_nxt, best_kmer_r, best_kmer_nxt;
  logic         have_r, have_nxt, out_valid_r, out_valid_nxt;

  logic [W-1:0] a_src, a_op, b_op, seed_len, hash_sum;
  logic [H-1:0] mul_a, mul_b;
  logic [W-1:0] prod;
  logic         is_mul, mul_done, out_free;

  assign seed_len = hash_seed ^ mkm_pkg::BLOCK_LEN;
  assign hash_sum = l1_r + l2_r;
  assign out_free = !out_valid_r || out_ready;

  assign job_ready = (state_r == mkm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Operand and constant of the multiply that each state performs
  always_comb begin
    is_mul = 1'b1;
    a_src  = '0;
    b_op   = '0;
    unique case (state_r)
      mkm_pkg::ST_KM1: begin
        a_src = job_r.kmer;
        b_op  = mkm_pkg::MURMUR_C1;
      end
      mkm_pkg::ST_KM2: begin
        a_src = {acc_r[32:0], acc_r[W-1:33]};
        b_op  = mkm_pkg::MURMUR_C2;
      end
      mkm_pkg::ST_F1A: begin
        a_src = mkm_pkg::xorshift33(l1_r);
        b_op  = mkm_pkg::FMIX_M1;
      end
      mkm_pkg::ST_F2A: begin
        a_src = mkm_pkg::xorshift33(l2_r);
        b_op  = mkm_pkg::FMIX_M1;
      end
      mkm_pkg::ST_F1B, mkm_pkg::ST_F2B: begin
        a_src = mkm_pkg::xorshift33(acc_r);
        b_op  = mkm_pkg::FMIX_M2;
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
  end

  // Low 64 bits of a 64x64 product as three partial products
  assign a_op = (sub_r == 2'd0) ? a_src : opnd_r;
  always_comb begin
    unique case (sub_r)
      2'd0: begin
        mul_a = a_op[H-1:0];
        mul_b = b_op[H-1:0];
      end
      2'd1: begin
        mul_a = a_op[H-1:0];
        mul_b = b_op[W-1:H];
      end
      default: begin
        mul_a = a_op[W-1:H];
        mul_b = b_op[H-1:0];
      end
    endcase
  end
  assign prod     = W'(mul_a) * W'(mul_b);
  assign mul_done = is_mul && (sub_r == 2'd2);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mkm_pkg::ST_IDLE: begin
        if (job_valid) begin
          state_nxt = job_data.has_kmer ? mkm_pkg::ST_KM1 : mkm_pkg::ST_EMIT;
        end
      end
      mkm_pkg::ST_KM1:   if (mul_done) state_nxt = mkm_pkg::ST_KM2;
      mkm_pkg::ST_KM2:   if (mul_done) state_nxt = mkm_pkg::ST_LANE1;
      mkm_pkg::ST_LANE1: state_nxt = mkm_pkg::ST_LANE2;
      mkm_pkg::ST_LANE2: state_nxt = mkm_pkg::ST_F1A;
      mkm_pkg::ST_F1A:   if (mul_done) state_nxt = mkm_pkg::ST_F1B;
      mkm_pkg::ST_F1B:   if (mul_done) state_nxt = mkm_pkg::ST_FIN1;
      mkm_pkg::ST_FIN1:  state_nxt = mkm_pkg::ST_F2A;
      mkm_pkg::ST_F2A:   if (mul_done) state_nxt = mkm_pkg::ST_F2B;
      mkm_pkg::ST_F2B:   if (mul_done) state_nxt = mkm_pkg::ST_FIN2;
      mkm_pkg::ST_FIN2:  state_nxt = mkm_pkg::ST_SUM;
      mkm_pkg::ST_SUM: begin
        state_nxt = job_r.last ? mkm_pkg::ST_EMIT : mkm_pkg::ST_IDLE;
      end
      mkm_pkg::ST_EMIT:  if (out_free) state_nxt = mkm_pkg::ST_IDLE;
      default:           state_nxt = mkm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    job_nxt       = job_r;
    sub_nxt       = '0;
    acc_nxt       = acc_r;
    opnd_nxt      = opnd_r;
    l1_nxt        = l1_r;
    l2_nxt        = l2_r;
    best_hash_nxt = best_hash_r;
    best_kmer_nxt = best_kmer_r;
    have_nxt      = have_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (is_mul) begin
      sub_nxt = mul_done ? 2'd0 : sub_r + 2'd1;
      if (sub_r == 2'd0) begin
        acc_nxt  = prod;
        opnd_nxt = a_src;
      end else begin
        acc_nxt = acc_r + {prod[H-1:0], {H{1'b0}}};
      end
    end

    unique case (state_r)
      mkm_pkg::ST_IDLE: begin
        if (job_valid) begin
          job_nxt = job_data;
        end
      end
      mkm_pkg::ST_LANE1: l1_nxt = (hash_seed ^ acc_r ^ mkm_pkg::BLOCK_LEN) + seed_len;
      mkm_pkg::ST_LANE2: l2_nxt = seed_len + l1_r;
      mkm_pkg::ST_FIN1:  l1_nxt = mkm_pkg::xorshift33(acc_r);
      mkm_pkg::ST_FIN2:  l2_nxt = mkm_pkg::xorshift33(acc_r);
      mkm_pkg::ST_SUM: begin
        // the first k-mer stands until a hash strictly below both its own and START_MIN turns up
        if (!have_r) begin
          best_kmer_nxt = job_r.kmer;
          have_nxt      = 1'b1;
        end
        if (hash_sum < best_hash_r) begin
          best_hash_nxt = hash_sum;
          best_kmer_nxt = job_r.kmer;
        end
      end
      mkm_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.minimizer_kmer = have_r ? best_kmer_r : '0;
          out_data_nxt.found          = have_r;
          best_hash_nxt               = mkm_pkg::START_MIN;
          best_kmer_nxt               = '0;
          have_nxt                    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mkm_pkg::ST_IDLE;
      sub_r       <= '0;
      best_hash_r <= mkm_pkg::START_MIN;
      best_kmer_r <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sub_r       <= sub_nxt;
      best_hash_r <= best_hash_nxt;
      best_kmer_r <= best_kmer_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    acc_r      <= acc_nxt;
    opnd_r     <= opnd_nxt;
    l1_r       <= l1_nxt;
    l2_r       <= l2_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[sv/murmur_kmer_minimizer.sv]
// Streaming k-mer minimizer ordered by MurmurHash3 x64 with fmix64.
//
// Input channel in_valid/in_ready/in_data carries one 2-bit base per item and
// a last-of-sequence flag. Output channel out_valid/out_ready/out_data gives
// one item per sequence, on its last base: the minimum-hash k-mer and a found
// flag. cfg_we/cfg_index/cfg_wdata write kmer_length (index 0) and hash_seed
// (index 1); write them only while the block is idle.
// Flow: a base that completes no k-mer and is not last posts no job, yet it
// is taken only while the queue has room. Each complete k-mer costs the back
// end six 64-bit multiplies, each done as three 32x32 partial products on the
// one shared multiplier, plus lane, finalise and compare steps; the back end
// takes no new job until it is idle again. A last base without a k-mer goes
// straight to the emit step. A four-entry queue lets the front run ahead by
// that many jobs. The result is registered from the emit step after the
// compare step of its last k-mer; that step waits while the output is full.
// Reset clears the window, the running minimum, the queue and the result
// valid flag, and sets kmer_length to 15 and hash_seed to 0. When the receiver
// stalls, the result is held in the output register; the back end then waits
// at the next result, the queue fills and in_ready drops.
// Depends on mkm_pkg, mkm_front, mkm_queue and mkm_hash_back.
`default_nettype none

module murmur_kmer_minimizer #(
  parameter int QUEUE_DEPTH = mkm_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mkm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mkm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire mkm_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mkm_pkg::out_item_t                   out_data
);

  logic [mkm_pkg::KMER_LEN_W-1:0] kmer_length_r;
  logic [mkm_pkg::SEED_W-1:0]     hash_seed_r;

  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  mkm_pkg::job_t fq_data, qb_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_length_r <= mkm_pkg::KMER_LEN_RESET;
      hash_seed_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mkm_pkg::CFG_KMER_LENGTH: kmer_length_r <= cfg_wdata[mkm_pkg::KMER_LEN_W-1:0];
        mkm_pkg::CFG_HASH_SEED:   hash_seed_r   <= cfg_wdata[mkm_pkg::SEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mkm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .kmer_length (kmer_length_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .job_valid   (fq_valid),
    .job_ready   (fq_ready),
    .job_data    (fq_data)
  );

  mkm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  mkm_hash_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hash_seed (hash_seed_r),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job_data  (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[tb/mkm_checker.sv]
// Watches the three ports of murmur_kmer_minimizer, tracks the k-mer minimum per read
// and compares every result item with the oldest expected one.
// Depends on mkm_pkg for the port types and register indexes.
`timescale 1ns / 100ps

module mkm_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mkm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mkm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  mkm_pkg::in_item_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  mkm_pkg::out_item_t              out_data,
  output int                              fail_count,
  output int                              pending
);

  localparam logic [63:0] BLK_MUL_A  = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] BLK_MUL_B  = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] AVAL_MUL_A = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] AVAL_MUL_B = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [63:0] RANK_CEIL  = 64'h7fff_ffff_ffff_ffff;

  logic [5:0]         klen_reg;
  logic [63:0]        seed_reg;
  logic [63:0]        roll_kmer;
  logic [5:0]         roll_count;
  logic [63:0]        low_rank;
  logic [63:0]        low_kmer;
  logic               any_full;
  mkm_pkg::out_item_t minimizer_q[$];
  mkm_pkg::out_item_t want;

  function automatic logic [5:0] window_bases(input logic [5:0] k);
    if (k == 6'd0) return 6'd1;
    if (k > 6'd32) return 6'd32;
    return k;
  endfunction

  function automatic logic [63:0] avalanche(input logic [63:0] v);
    logic [63:0] x;
    x = v ^ (v >> 33);
    x = x * AVAL_MUL_A;
    x = x ^ (x >> 33);
    x = x * AVAL_MUL_B;
    return x ^ (x >> 33);
  endfunction

  // Single 8-byte block: mix into lane one, cross-add, avalanche both lanes
  function automatic logic [63:0] kmer_rank(input logic [63:0] kmer, input logic [63:0] seed);
    logic [63:0] blk;
    logic [63:0] h1;
    logic [63:0] h2;
    blk = kmer * BLK_MUL_A;
    blk = {blk[32:0], blk[63:33]};
    blk = blk * BLK_MUL_B;
    h1 = seed ^ blk ^ 64'd8;
    h2 = seed ^ 64'd8;
    h1 = h1 + h2;
    h2 = h2 + h1;
    h1 = avalanche(h1);
    h2 = avalanche(h2);
    return h1 + h2;
  endfunction

  task automatic clear_read();
    roll_kmer  = '0;
    roll_count = '0;
    low_rank   = RANK_CEIL;
    low_kmer   = '0;
    any_full   = 1'b0;
  endtask

  task automatic take_base(input mkm_pkg::in_item_t it);
    logic [5:0]         k;
    logic [63:0]        mask;
    logic [63:0]        rank;
    mkm_pkg::out_item_t res;
    k    = window_bases(klen_reg);
    mask = (k == 6'd32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    roll_kmer = ((roll_kmer << 2) | 64'(it.base_code)) & mask;
    if (roll_count < k) roll_count = roll_count + 6'd1;
    // length may have shrunk since the last base
    if (roll_count > k) roll_count = k;
    if (roll_count == k) begin
      rank = kmer_rank(roll_kmer, seed_reg);
      if (!any_full) begin
        low_kmer = roll_kmer;
        any_full = 1'b1;
      end
      if (rank < low_rank) begin
        low_rank = rank;
        low_kmer = roll_kmer;
      end
    end
    if (it.last_base) begin
      res.minimizer_kmer = any_full ? low_kmer : '0;
      res.found          = any_full;
      minimizer_q.insert(minimizer_q.size(), res);
      clear_read();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      klen_reg   = mkm_pkg::KMER_LEN_RESET;
      seed_reg   = '0;
      fail_count = 0;
      minimizer_q.delete();
      clear_read();
    end else begin
      if (cfg_we) begin
        if (cfg_index == mkm_pkg::CFG_KMER_LENGTH) klen_reg = cfg_wdata[5:0];
        else if (cfg_index == mkm_pkg::CFG_HASH_SEED) seed_reg = cfg_wdata;
      end
      // compare before predicting: a result never leaves in the cycle its base enters
      if (out_valid && out_ready) begin
        if (minimizer_q.size() == 0) begin
          $error("unexpected result item: minimizer_kmer %h found %b",
                 out_data.minimizer_kmer, out_data.found);
          fail_count++;
        end else begin
          want = minimizer_q.pop_front();
          if (out_data.minimizer_kmer !== want.minimizer_kmer) begin
            $error("minimizer_kmer: expected %h, actual %h",
                   want.minimizer_kmer, out_data.minimizer_kmer);
            fail_count++;
          end
          if (out_data.found !== want.found) begin
            $error("found: expected %b, actual %b", want.found, out_data.found);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) take_base(in_data);
    end
    pending = minimizer_q.size();
  end

endmodule

[tb/tb.sv]
// Top of the murmur_kmer_minimizer testbench: clock, reset, base stimulus,
// register writes, receiver stalls, watchdog and verdict.
// Depends on mkm_pkg, murmur_kmer_minimizer and mkm_checker.
`timescale 1ns / 100ps

module tb;

  // Longest legitimate quiet stretch: a full queue of k-mer jobs
  // behind a stalling receiver, or a settle pause plus register writes.
  localparam int QUIET_LIMIT = 20000;
  // Four queued k-mer jobs plus one in flight, and the output stage
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS   = 105;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [mkm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mkm_pkg::CFG_DATA_W-1:0]  cfg_wdata;
  logic                            in_valid;
  logic                            in_ready;
  mkm_pkg::in_item_t               in_data;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  mkm_pkg::out_item_t              out_data;
  int                              fail_count;
  int                              pending;
  int                              send_idle_pct;
  int                              recv_stall_pct;
  int                              quiet_cycles = 0;

  murmur_kmer_minimizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mkm_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Entered and left just after a falling edge; valid stays up between items unless an idle gap is drawn
  task automatic send_base(input logic [1:0] code, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{base_code: code, last_base: is_last};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [mkm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every expected result is out, then let the back end drain
  task automatic wait_results(input int extra);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic send_read(input int len);
    logic       flat;
    logic [1:0] code;
    flat = ($urandom_range(7) == 0);
    code = 2'($urandom_range(3));
    for (int i = 0; i < len; i++) begin
      if (!flat) code = 2'($urandom_range(3));
      send_base(code, i == len - 1);
    end
  endtask

  task automatic run_phase(input logic [63:0] klen_val, input logic [63:0] seed_val,
                           input int idle_pct, input int stall_pct);
    int k;
    int len;
    int sent;
    wait_results(SETTLE_CYCLES);
    write_reg(mkm_pkg::CFG_KMER_LENGTH, klen_val);
    write_reg(mkm_pkg::CFG_HASH_SEED, seed_val);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    k = int'(klen_val[5:0]);
    if (k == 0) k = 1;
    if (k > 32) k = 32;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      case ($urandom_range(9))
        0: len = (k > 1) ? $urandom_range(1, k - 1) : 1;
        1: len = k + $urandom_range(20, 60);
        default: len = k + $urandom_range(0, 8);
      endcase
      if ($urandom_range(29) == 0) wait_results(0);
      send_read(len);
      sent += len;
    end
  endtask

  initial begin
    logic [63:0] klens[8];
    logic [63:0] seeds[8];
    int          idle_pcts[4];
    int          stall_pcts[4];
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    klens      = '{64'd1, 64'd32, 64'd63, 64'($urandom_range(2, 31)),
                   64'd0, 64'd7, 64'd20, 64'd15};
    seeds      = '{64'd0, '1, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, '1, 64'd0, {$urandom, $urandom}};
    idle_pcts  = '{0, 76, 0, 29};
    stall_pcts = '{0, 0, 76, 29};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single-base windows, one-base reads and a two-base read
    write_reg(mkm_pkg::CFG_KMER_LENGTH, 64'd1);
    write_reg(mkm_pkg::CFG_HASH_SEED, 64'd0);
    send_base(2'd0, 1'b1);
    send_base(2'd3, 1'b1);
    send_base(2'd1, 1'b0);
    send_base(2'd2, 1'b1);

    // zero length behaves as one; upper data bits are ignored
    wait_results(SETTLE_CYCLES);
    write_reg(mkm_pkg::CFG_KMER_LENGTH, 64'hffff_ffff_ffff_ffc0);
    send_base(2'd2, 1'b0);
    send_base(2'd3, 1'b1);

    // repeated k-mers tie; a read shorter than k finds nothing
    wait_results(SETTLE_CYCLES);
    write_reg(mkm_pkg::CFG_KMER_LENGTH, 64'd2);
    send_base(2'd3, 1'b0);
    send_base(2'd3, 1'b0);
    send_base(2'd3, 1'b1);
    send_base(2'd1, 1'b1);

    // shrink the window in the middle of a read
    wait_results(SETTLE_CYCLES);
    write_reg(mkm_pkg::CFG_KMER_LENGTH, 64'd3);
    send_base(2'd0, 1'b0);
    send_base(2'd1, 1'b0);
    send_base(2'd2, 1'b0);
    wait_results(SETTLE_CYCLES);
    write_reg(mkm_pkg::CFG_KMER_LENGTH, 64'd2);
    send_base(2'd3, 1'b0);
    send_base(2'd1, 1'b1);

    // length above 32 clamps; short read with an all-ones seed
    wait_results(SETTLE_CYCLES);
    write_reg(mkm_pkg::CFG_KMER_LENGTH, 64'd63);
    write_reg(mkm_pkg::CFG_HASH_SEED, '1);
    send_base(2'd0, 1'b0);
    send_base(2'd3, 1'b1);

    for (int p = 0; p < 8; p++) begin
      run_phase(klens[p], seeds[p], idle_pcts[p % 4], stall_pcts[p % 4]);
    end

    wait_results(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mkm_pkg.sv
sv/mkm_front.sv
sv/mkm_queue.sv
sv/mkm_hash_back.sv
sv/murmur_kmer_minimizer.sv
tb/mkm_checker.sv
tb/tb.sv
